[sv/cfd_pkg.sv]
// Package with shared types, constants and the CRC step of the frame deframer.
package cfd_pkg;

   localparam int DefaultStoreDepth = 256;

   localparam logic [7:0]  HeaderByte0   = 8'hEB;
   localparam logic [7:0]  HeaderByte1   = 8'h90;
   localparam logic [15:0] CrcInit       = 16'hFFFF;
   localparam logic [15:0] CrcPoly       = 16'hA001;
   localparam logic [7:0]  MaxLenReset   = 8'd249;
   localparam int          FrameOverhead = 7;

   typedef enum logic [2:0] {
      PH_SEARCH, PH_HDR2, PH_VERSION, PH_LEN_HI,
      PH_LEN_LO, PH_DATA, PH_CRC_HI, PH_CRC_LO
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_SCAN, ST_EMIT_FETCH, ST_EMIT_CAPTURE, ST_EMIT_PUSH
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic scan_read;
      logic scan_step;
      logic emit_read;
      logic emit_capture;
      logic emit_push;
   } cmd_type;

   typedef struct packed {
      logic scan_pending;
      logic frame_good;
      logic word_full;
      logic out_free;
      logic emit_last;
   } status_type;

   // One byte of reflected CRC-16/MODBUS, bit by bit.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[sv/cfd_req_if.sv]
// Input channel interface: one received byte per transfer.
interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

[sv/cfd_rsp_if.sv]
// Result channel interface: one frame word per transfer.
interface cfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] frame_word;
   logic [3:0]  word_bytes;
   logic        last_word;
   logic [8:0]  frame_length;
   modport source (output valid, output frame_word, output word_bytes, output last_word,
                   output frame_length, input ready);
   modport sink (input valid, input frame_word, input word_bytes, input last_word,
                 input frame_length, output ready);
endinterface

[sv/cfd_ctrl.sv]
// Controller state machine sequencing byte intake, scanning and word emission.
module cfd_ctrl
   import cfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_byte = 1'b1;
               state_in      = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (status.scan_pending) begin
               cmd.scan_read = 1'b1;
               state_in      = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            state_in      = status.frame_good ? ST_EMIT_FETCH : ST_FETCH;
         end
         ST_EMIT_FETCH: begin
            cmd.emit_read = 1'b1;
            state_in      = ST_EMIT_CAPTURE;
         end
         ST_EMIT_CAPTURE: begin
            cmd.emit_capture = 1'b1;
            state_in         = status.word_full ? ST_EMIT_PUSH : ST_EMIT_FETCH;
         end
         ST_EMIT_PUSH: begin
            if (status.out_free) begin
               cmd.emit_push = 1'b1;
               state_in      = status.emit_last ? ST_FETCH : ST_EMIT_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/cfd_datapath.sv]
// Datapath: circular byte store, frame scanner, CRC and output word register.
module cfd_datapath
   import cfd_pkg::*;
#(
   parameter int FRAME_STORE_DEPTH = DefaultStoreDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic [7:0]  rx_byte,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [63:0] rsp_frame_word,
   output logic [3:0]  rsp_word_bytes,
   output logic        rsp_last_word,
   output logic [8:0]  rsp_frame_length
);

   localparam int AW = $clog2(FRAME_STORE_DEPTH);
   localparam int CW = $clog2(FRAME_STORE_DEPTH + 1);
   localparam logic [CW:0] Depth = (CW + 1)'(FRAME_STORE_DEPTH);

   logic [7:0] mem [FRAME_STORE_DEPTH];
   logic [7:0] rd_data_ff;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] held_ff, held_in;
   logic [CW-1:0] replay_ff, replay_in;
   phase_type     phase_ff, phase_in;
   logic [7:0]    dlen_ff, dlen_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    crc_hi_ff, crc_hi_in;
   logic [7:0]    max_len_ff;

   logic [8:0]    total_ff, total_in;
   logic [8:0]    pos_ff, pos_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [63:0]   acc_ff, acc_in;

   logic          out_valid_ff, out_valid_in;
   logic [63:0]   out_word_ff;
   logic [3:0]    out_bytes_ff;
   logic          out_last_ff;
   logic [8:0]    out_len_ff;

   logic [CW:0]   wr_sum, rd_sum, head_sum;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [CW:0]   drop_cnt;
   logic          drop;
   logic          good;

   // Circular addressing: head plus an offset below twice the depth.
   always_comb begin
      wr_sum = {{(CW + 1 - AW){1'b0}}, head_ff} + {1'b0, held_ff};
      if (wr_sum >= Depth) begin
         wr_sum = wr_sum - Depth;
      end
      wr_addr = wr_sum[AW-1:0];
      if (cmd.scan_read) begin
         rd_sum = {{(CW + 1 - AW){1'b0}}, head_ff} + {1'b0, replay_ff};
      end else begin
         rd_sum = {{(CW + 1 - AW){1'b0}}, head_ff} + (CW + 1)'(pos_ff);
      end
      if (rd_sum >= Depth) begin
         rd_sum = rd_sum - Depth;
      end
      rd_addr = rd_sum[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte && (held_ff < CW'(FRAME_STORE_DEPTH))) begin
         mem[wr_addr] <= rx_byte;
      end
      if (cmd.scan_read || cmd.emit_read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign good = (phase_ff == PH_CRC_LO) && ({crc_hi_ff, rd_data_ff} == crc_ff);

   always_comb begin
      head_in      = head_ff;
      held_in      = held_ff;
      replay_in    = replay_ff;
      phase_in     = phase_ff;
      dlen_in      = dlen_ff;
      crc_in       = crc_ff;
      crc_hi_in    = crc_hi_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      drop         = 1'b0;
      drop_cnt     = '0;

      if (cmd.take_byte && (held_ff < CW'(FRAME_STORE_DEPTH))) begin
         held_in = held_ff + 1'b1;
      end

      if (cmd.scan_step) begin
         case (phase_ff)
            PH_SEARCH: begin
               if (rd_data_ff == HeaderByte0) begin
                  crc_in    = crc_byte(CrcInit, rd_data_ff);
                  replay_in = CW'(1);
                  phase_in  = PH_HDR2;
               end else begin
                  drop      = 1'b1;
                  replay_in = '0;
               end
            end
            PH_HDR2: begin
               if (rd_data_ff == HeaderByte1) begin
                  crc_in    = crc_byte(crc_ff, rd_data_ff);
                  replay_in = replay_ff + 1'b1;
                  phase_in  = PH_VERSION;
               end else begin
                  drop = 1'b1;
               end
            end
            PH_VERSION: begin
               crc_in    = crc_byte(crc_ff, rd_data_ff);
               replay_in = replay_ff + 1'b1;
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               if (rd_data_ff != 8'h00) begin
                  drop = 1'b1;
               end else begin
                  crc_in    = crc_byte(crc_ff, rd_data_ff);
                  replay_in = replay_ff + 1'b1;
                  phase_in  = PH_LEN_LO;
               end
            end
            PH_LEN_LO: begin
               if ((rd_data_ff > max_len_ff) ||
                   ((13'(rd_data_ff) + 13'(FrameOverhead)) > 13'(FRAME_STORE_DEPTH))) begin
                  drop = 1'b1;
               end else begin
                  dlen_in   = rd_data_ff;
                  crc_in    = crc_byte(crc_ff, rd_data_ff);
                  replay_in = replay_ff + 1'b1;
                  phase_in  = (rd_data_ff != 8'h00) ? PH_DATA : PH_CRC_HI;
               end
            end
            PH_DATA: begin
               crc_in    = crc_byte(crc_ff, rd_data_ff);
               replay_in = replay_ff + 1'b1;
               if ((14'(replay_ff) + 14'd1) >= (14'd5 + 14'(dlen_ff))) begin
                  phase_in = PH_CRC_HI;
               end
            end
            PH_CRC_HI: begin
               crc_hi_in = rd_data_ff;
               replay_in = replay_ff + 1'b1;
               phase_in  = PH_CRC_LO;
            end
            default: begin
               if (good) begin
                  total_in = 9'(replay_ff) + 9'd1;
                  pos_in   = '0;
                  cnt_in   = '0;
                  acc_in   = '0;
                  phase_in  = PH_SEARCH;
                  replay_in = '0;
                  crc_in    = CrcInit;
                  dlen_in   = '0;
               end else begin
                  drop = 1'b1;
               end
            end
         endcase
         // A rejected candidate loses its first byte and the search restarts.
         if (drop) begin
            drop_cnt = (CW + 1)'(1);
            if (phase_ff != PH_SEARCH) begin
               phase_in  = PH_SEARCH;
               replay_in = '0;
               crc_in    = CrcInit;
               dlen_in   = '0;
            end
         end
      end

      if (cmd.emit_capture) begin
         acc_in[(7 - cnt_ff[2:0]) * 8 +: 8] = rd_data_ff;
         cnt_in = cnt_ff + 1'b1;
         pos_in = pos_ff + 1'b1;
      end

      if (cmd.emit_push) begin
         out_valid_in = 1'b1;
         acc_in       = '0;
         cnt_in       = '0;
         if (pos_ff == total_ff) begin
            drop_cnt = (CW + 1)'(total_ff);
         end
      end

      if (drop_cnt != '0) begin
         head_sum = {{(CW + 1 - AW){1'b0}}, head_ff} + drop_cnt;
         if (head_sum >= Depth) begin
            head_sum = head_sum - Depth;
         end
         head_in = head_sum[AW-1:0];
         held_in = held_ff - drop_cnt[CW-1:0];
      end else begin
         head_sum = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         held_ff      <= '0;
         replay_ff    <= '0;
         phase_ff     <= PH_SEARCH;
         dlen_ff      <= '0;
         crc_ff       <= CrcInit;
         max_len_ff   <= MaxLenReset;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         held_ff      <= held_in;
         replay_ff    <= replay_in;
         phase_ff     <= phase_in;
         dlen_ff      <= dlen_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      crc_hi_ff <= crc_hi_in;
      total_ff  <= total_in;
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      if (cmd.emit_push) begin
         out_word_ff  <= acc_ff;
         out_bytes_ff <= cnt_ff;
         out_last_ff  <= (pos_ff == total_ff);
         out_len_ff   <= total_ff;
      end
   end

   always_comb begin
      status.scan_pending = (replay_ff < held_ff);
      status.frame_good   = good;
      status.word_full    = (cnt_ff == 4'd7) || ((pos_ff + 9'd1) == total_ff);
      status.out_free     = !out_valid_ff || rsp_ready;
      status.emit_last    = (pos_ff == total_ff);
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_word   = out_word_ff;
   assign rsp_word_bytes   = out_bytes_ff;
   assign rsp_last_word    = out_last_ff;
   assign rsp_frame_length = out_len_ff;

endmodule

[sv/crc16_checked_frame_deframer.sv]
// Top level of the CRC-16 checked, length-prefixed frame deframer.
//
// The req channel carries one received byte per transfer. The block searches
// the byte stream for frames: 0xEB 0x90, a version byte, a big-endian 16-bit
// data length, the data, and a big-endian CRC-16/MODBUS over all bytes before
// it. Each good frame leaves on the rsp channel as 8-byte words, earliest byte
// in the most significant byte, with the last word flagged and the total frame
// length repeated on every word.
// Sequencing: a byte transfer is stored first, then each byte scanned takes a
// memory read and a scanner step, and the controller goes back to idle once
// it finds nothing left to scan; only then is the next transfer taken. A
// rejected candidate drops its first byte and replays the rest of the store,
// a memory read and a scanner step per replayed byte, with req held off. A
// good frame is read back from the store with a fetch and a capture per byte
// plus a push per word; the single memory read port sets this order. The csr
// port writes the largest accepted data length.
// Reset clears the pointers, the scanner and the output register; the store
// itself needs no clearing. When the receiver stalls, the finished word waits
// in the output register and emission pauses until it is taken.
module crc16_checked_frame_deframer
   import cfd_pkg::*;
#(
   parameter int FRAME_STORE_DEPTH = DefaultStoreDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   cfd_req_if.sink    req,
   cfd_rsp_if.source  rsp
);

   cmd_type    cmd;
   status_type status;

   cfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cfd_datapath #(
      .FRAME_STORE_DEPTH (FRAME_STORE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rx_byte          (req.rx_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_frame_word   (rsp.frame_word),
      .rsp_word_bytes   (rsp.word_bytes),
      .rsp_last_word    (rsp.last_word),
      .rsp_frame_length (rsp.frame_length)
   );

endmodule

[sv/cfd_checker.sv]
// Port-level checker for the frame deframer, bound to the top level.
module cfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_word_bytes,
   input logic       rsp_last_word,
   input logic [8:0] rsp_frame_length
);

   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_word_bytes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word_bytes != 4'd0) && (rsp_word_bytes <= 4'd8))
      else $error("word byte count out of range");

   a_full_inner_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_word |-> rsp_word_bytes == 4'd8)
      else $error("short word before the end of a frame");

   a_min_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_length >= 9'd7)
      else $error("frame shorter than header and CRC");

endmodule

bind crc16_checked_frame_deframer cfd_checker u_cfd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_word_bytes   (rsp.word_bytes),
   .rsp_last_word    (rsp.last_word),
   .rsp_frame_length (rsp.frame_length)
);
